[src/plucked_string_voice_macros.svh]
// ----------------------------------------------------------------------------
// plucked_string_voice assertion macros
// Shared property forms used by the string voice checker.
// ----------------------------------------------------------------------------
`ifndef PLUCKED_STRING_VOICE_MACROS_SVH
`define PLUCKED_STRING_VOICE_MACROS_SVH

// Antecedent implies consequent in the next cycle.
`define PSV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("plucked_string_voice: next-cycle check failed");

// Antecedent implies consequent in the same cycle.
`define PSV_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("plucked_string_voice: same-cycle check failed");

`endif

[src/psv_pkg.sv]
// ----------------------------------------------------------------------------
// psv_pkg
// Types and constants of the plucked string voice.
// ----------------------------------------------------------------------------
package psv_pkg;

    // Input word commands
    localparam logic CMD_PLUCK = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_FEEDBACK = 2'd0;
    localparam logic [1:0] REG_ALLPASS  = 2'd1;

    // Feedback gain, unsigned Q0.15
    localparam logic [14:0] FB_MIN   = 15'd16384;
    localparam logic [14:0] FB_MAX   = 15'd32735;
    localparam logic [14:0] FB_RESET = 15'd32637;

    // All-pass coefficient, signed Q1.15
    localparam logic signed [15:0] AP_COEF_RESET = 16'sd9830;
    localparam logic signed [15:0] AP_COEF_MOST_NEG = 16'sh8000;
    localparam logic signed [15:0] AP_COEF_MIN   = 16'sh8001;

    // All-pass state limits, Q16.8 in 24 bits
    localparam int AP_STATE_MAX = 8388607;

    // Noise burst generator
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Division by 127: floor(2^22 / 127), then one correction step
    localparam int          RECIP_SHIFT = 22;
    localparam logic [17:0] RECIP_127   = 18'd33026;
    localparam logic [23:0] DIV_127     = 24'd127;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PL_MULV,
        ST_PL_MULR,
        ST_PL_WR,
        ST_TK_RD1,
        ST_TK_SUM,
        ST_TK_FB,
        ST_TK_AP,
        ST_TK_APSUM,
        ST_TK_FBK,
        ST_TK_ENV,
        ST_TK_OUT
    } state_t;

endpackage

[src/plucked_string_voice.sv]
// ----------------------------------------------------------------------------
// plucked_string_voice
// Tick: states RD1, SUM, FB, AP, APSUM, FBK, ENV, OUT; OUT registers the
//   result and waits while the output word is stalled; no-result ticks stay
//   in IDLE. Pluck: MULV, MULR, WR per burst word, each using the shared
//   multiplier twice (velocity scaling, then division by 127 via reciprocal).
// Reset (aresetn low, synchronous): voice inactive, length 2, position and
//   all-pass state zero, registers at defaults. Delay line is not cleared.
// ----------------------------------------------------------------------------
module plucked_string_voice #(
    parameter int MAX_DELAY   = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [15:0]                   cfg_wdata,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [11:0]                   s_delay_length,
    input  logic [6:0]                    s_velocity,
    input  logic [15:0]                   s_envelope_gain,
    input  logic                          s_envelope_idle,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample
);

    localparam int ADDR_W  = $clog2(MAX_DELAY);
    localparam int LEN_W   = $clog2(MAX_DELAY + 1);
    localparam int CLAMP_W = (LEN_W > 12) ? LEN_W : 12;
    localparam int A_W     = (SAMPLE_BITS + 8 > 24) ? SAMPLE_BITS + 8 : 24;
    localparam int B_W     = 18;
    localparam int P_W     = A_W + B_W;

    localparam logic signed [P_W-1:0] SMP_MAX = P_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [P_W-1:0] SMP_MIN = -SMP_MAX - P_W'(1);
    localparam logic signed [P_W-1:0] APS_MAX = P_W'(psv_pkg::AP_STATE_MAX);
    localparam logic signed [P_W-1:0] APS_MIN = -APS_MAX - P_W'(1);

    psv_pkg::state_t state_reg, state_next;

    // control and configuration
    logic [14:0]              fb_reg;
    logic signed [15:0]       coeff_reg;
    logic [LEN_W-1:0]         loop_len_reg;
    logic [ADDR_W-1:0]        read_pos_reg;
    logic signed [23:0]       apmem_reg;
    logic                     active_reg;
    logic [15:0]              lfsr_reg;
    logic [ADDR_W-1:0]        pl_idx_reg;
    logic                     m_valid_reg;

    // payload
    logic [6:0]               vel_reg;
    logic [15:0]              env_reg;
    logic                     pl_neg_reg;
    logic [21:0]              pl_mag_reg;
    logic signed [SAMPLE_BITS-1:0] cur_reg;
    logic signed [SAMPLE_BITS:0]   sum_reg;
    logic signed [SAMPLE_BITS+7:0] avg_reg;
    logic signed [23:0]       ap_reg;
    logic signed [SAMPLE_BITS-1:0] rdata_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg;

    // delay line
    logic [SAMPLE_BITS-1:0]   delay_mem [MAX_DELAY];

    logic                     accept;
    logic                     pl_last;
    logic [CLAMP_W-1:0]       len_ext;
    logic [LEN_W-1:0]         len_clamped;
    logic [LEN_W-1:0]         pos_inc;
    logic [ADDR_W-1:0]        nxt_pos;
    logic [15:0]              lfsr_step;

    logic                     mul_en;
    logic signed [A_W-1:0]    mul_a;
    logic signed [B_W-1:0]    mul_b;
    logic signed [P_W-1:0]    prod;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [SAMPLE_BITS-1:0]   mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;

    logic signed [P_W-1:0]    pl_abs;
    logic [15:0]              pl_qest;
    logic [23:0]              pl_rem;
    logic [16:0]              pl_q;
    logic signed [P_W-1:0]    pl_val;
    logic signed [SAMPLE_BITS-1:0] pl_word;

    logic signed [P_W-1:0]    ap_sum;
    logic signed [23:0]       ap_sat;
    logic signed [P_W-1:0]    apm_sum;
    logic signed [23:0]       apm_sat;
    logic signed [P_W-1:0]    wb_div;
    logic signed [SAMPLE_BITS-1:0] wb_word;
    logic signed [P_W-1:0]    smp_div;
    logic signed [SAMPLE_BITS-1:0] smp_sat;

    assign s_ready  = (state_reg == psv_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    // length clamp to 2..MAX_DELAY
    assign len_ext = CLAMP_W'(s_delay_length);
    always_comb begin
        if (len_ext < CLAMP_W'(2)) begin
            len_clamped = LEN_W'(2);
        end else if (len_ext > CLAMP_W'(MAX_DELAY)) begin
            len_clamped = LEN_W'(MAX_DELAY);
        end else begin
            len_clamped = len_ext[LEN_W-1:0];
        end
    end

    // position wrap
    assign pos_inc = LEN_W'(read_pos_reg) + LEN_W'(1);
    assign nxt_pos = (pos_inc == loop_len_reg) ? '0 : pos_inc[ADDR_W-1:0];
    assign pl_last = (LEN_W'(pl_idx_reg) == loop_len_reg - LEN_W'(1));

    // Galois LFSR, shift right
    assign lfsr_step = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? psv_pkg::LFSR_TAPS : 16'd0);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            psv_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_command == psv_pkg::CMD_PLUCK) begin
                        state_next = psv_pkg::ST_PL_MULV;
                    end else if (active_reg && !s_envelope_idle) begin
                        state_next = psv_pkg::ST_TK_RD1;
                    end
                end
            end
            psv_pkg::ST_PL_MULV:  state_next = psv_pkg::ST_PL_MULR;
            psv_pkg::ST_PL_MULR:  state_next = psv_pkg::ST_PL_WR;
            psv_pkg::ST_PL_WR: begin
                state_next = pl_last ? psv_pkg::ST_IDLE : psv_pkg::ST_PL_MULV;
            end
            psv_pkg::ST_TK_RD1:   state_next = psv_pkg::ST_TK_SUM;
            psv_pkg::ST_TK_SUM:   state_next = psv_pkg::ST_TK_FB;
            psv_pkg::ST_TK_FB:    state_next = psv_pkg::ST_TK_AP;
            psv_pkg::ST_TK_AP:    state_next = psv_pkg::ST_TK_APSUM;
            psv_pkg::ST_TK_APSUM: state_next = psv_pkg::ST_TK_FBK;
            psv_pkg::ST_TK_FBK:   state_next = psv_pkg::ST_TK_ENV;
            psv_pkg::ST_TK_ENV:   state_next = psv_pkg::ST_TK_OUT;
            psv_pkg::ST_TK_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = psv_pkg::ST_IDLE;
                end
            end
            default:              state_next = psv_pkg::ST_IDLE;
        endcase
    end

    // Multiplier operands and delay line port controls
    always_comb begin
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mem_we    = 1'b0;
        mem_waddr = read_pos_reg;
        mem_wdata = wb_word;
        mem_raddr = read_pos_reg;
        unique case (state_reg)
            psv_pkg::ST_PL_MULV: begin
                mul_en = 1'b1;
                mul_a  = A_W'($signed(lfsr_step));
                mul_b  = B_W'(vel_reg);
            end
            psv_pkg::ST_PL_MULR: begin
                mul_en = 1'b1;
                mul_a  = A_W'(pl_abs[21:0]);
                mul_b  = psv_pkg::RECIP_127;
            end
            psv_pkg::ST_PL_WR: begin
                mem_we    = 1'b1;
                mem_waddr = pl_idx_reg;
                mem_wdata = pl_word;
            end
            psv_pkg::ST_TK_RD1: begin
                mem_raddr = nxt_pos;
            end
            psv_pkg::ST_TK_FB: begin
                mul_en = 1'b1;
                mul_a  = A_W'(sum_reg);
                mul_b  = B_W'(fb_reg);
            end
            psv_pkg::ST_TK_AP: begin
                mul_en = 1'b1;
                mul_a  = A_W'(prod >>> 8);
                mul_b  = -B_W'(coeff_reg);
            end
            psv_pkg::ST_TK_FBK: begin
                mul_en = 1'b1;
                mul_a  = A_W'(ap_reg);
                mul_b  = B_W'(coeff_reg);
                mem_we = 1'b1;
            end
            psv_pkg::ST_TK_ENV: begin
                mul_en = 1'b1;
                mul_a  = A_W'(ap_reg);
                mul_b  = B_W'(env_reg);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    psv_mul #(
        .A_WIDTH (A_W),
        .B_WIDTH (B_W)
    ) u_mul (
        .aclk    (aclk),
        .mul_en  (mul_en),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .prod    (prod)
    );

    // Burst word: |w*vel| / 127 by reciprocal, one correction, sign restored
    assign pl_abs  = prod[P_W-1] ? -prod : prod;
    assign pl_qest = prod[psv_pkg::RECIP_SHIFT +: 16];
    assign pl_rem  = 24'(pl_mag_reg) - (24'(pl_qest) << 7) + 24'(pl_qest);
    assign pl_q    = (pl_rem >= psv_pkg::DIV_127) ? 17'(pl_qest) + 17'd1 : 17'(pl_qest);
    assign pl_val  = pl_neg_reg ? -P_W'(pl_q) : P_W'(pl_q);
    always_comb begin
        if (pl_val > SMP_MAX) begin
            pl_word = SMP_MAX[SAMPLE_BITS-1:0];
        end else if (pl_val < SMP_MIN) begin
            pl_word = SMP_MIN[SAMPLE_BITS-1:0];
        end else begin
            pl_word = pl_val[SAMPLE_BITS-1:0];
        end
    end

    // All-pass output: floor(-c*avg / 2^15) + state, saturated to 24 bits
    assign ap_sum = (prod >>> 15) + P_W'(apmem_reg);
    always_comb begin
        if (ap_sum > APS_MAX) begin
            ap_sat = APS_MAX[23:0];
        end else if (ap_sum < APS_MIN) begin
            ap_sat = APS_MIN[23:0];
        end else begin
            ap_sat = ap_sum[23:0];
        end
    end

    // All-pass state: avg + floor(c*ap / 2^15), saturated
    assign apm_sum = P_W'(avg_reg) + (prod >>> 15);
    always_comb begin
        if (apm_sum > APS_MAX) begin
            apm_sat = APS_MAX[23:0];
        end else if (apm_sum < APS_MIN) begin
            apm_sat = APS_MIN[23:0];
        end else begin
            apm_sat = apm_sum[23:0];
        end
    end

    // Write-back word: ap / 2^8 toward zero, saturated
    assign wb_div = (P_W'(ap_reg) >>> 8)
                  + ((ap_reg < 0 && ap_reg[7:0] != 8'd0) ? P_W'(1) : P_W'(0));
    always_comb begin
        if (wb_div > SMP_MAX) begin
            wb_word = SMP_MAX[SAMPLE_BITS-1:0];
        end else if (wb_div < SMP_MIN) begin
            wb_word = SMP_MIN[SAMPLE_BITS-1:0];
        end else begin
            wb_word = wb_div[SAMPLE_BITS-1:0];
        end
    end

    // Output sample: ap*env / 2^23 toward zero, saturated
    assign smp_div = (prod >>> 23)
                   + ((prod < 0 && prod[22:0] != 23'd0) ? P_W'(1) : P_W'(0));
    always_comb begin
        if (smp_div > SMP_MAX) begin
            smp_sat = SMP_MAX[SAMPLE_BITS-1:0];
        end else if (smp_div < SMP_MIN) begin
            smp_sat = SMP_MIN[SAMPLE_BITS-1:0];
        end else begin
            smp_sat = smp_div[SAMPLE_BITS-1:0];
        end
    end

    // Delay line, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            delay_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= $signed(delay_mem[mem_raddr]);
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= psv_pkg::ST_IDLE;
            fb_reg       <= psv_pkg::FB_RESET;
            coeff_reg    <= psv_pkg::AP_COEF_RESET;
            loop_len_reg <= LEN_W'(2);
            read_pos_reg <= '0;
            apmem_reg    <= '0;
            active_reg   <= 1'b0;
            lfsr_reg     <= psv_pkg::LFSR_SEED;
            pl_idx_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            // register writes, clamped
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    psv_pkg::REG_FEEDBACK: begin
                        if (cfg_wdata[14:0] < psv_pkg::FB_MIN) begin
                            fb_reg <= psv_pkg::FB_MIN;
                        end else if (cfg_wdata[14:0] > psv_pkg::FB_MAX) begin
                            fb_reg <= psv_pkg::FB_MAX;
                        end else begin
                            fb_reg <= cfg_wdata[14:0];
                        end
                    end
                    psv_pkg::REG_ALLPASS: begin
                        if ($signed(cfg_wdata) == psv_pkg::AP_COEF_MOST_NEG) begin
                            coeff_reg <= psv_pkg::AP_COEF_MIN;
                        end else begin
                            coeff_reg <= $signed(cfg_wdata);
                        end
                    end
                    default: begin
                        fb_reg <= fb_reg;
                    end
                endcase
            end

            // word acceptance
            if (accept) begin
                if (s_command == psv_pkg::CMD_PLUCK) begin
                    loop_len_reg <= len_clamped;
                    read_pos_reg <= '0;
                    apmem_reg    <= '0;
                    active_reg   <= 1'b1;
                    lfsr_reg     <= psv_pkg::LFSR_SEED;
                    pl_idx_reg   <= '0;
                end else if (active_reg && s_envelope_idle) begin
                    active_reg <= 1'b0;
                end
            end

            // burst generation
            if (state_reg == psv_pkg::ST_PL_MULV) begin
                lfsr_reg <= lfsr_step;
            end
            if (state_reg == psv_pkg::ST_PL_WR) begin
                pl_idx_reg <= pl_idx_reg + ADDR_W'(1);
            end

            // loop update
            if (state_reg == psv_pkg::ST_TK_FBK) begin
                read_pos_reg <= nxt_pos;
            end
            if (state_reg == psv_pkg::ST_TK_ENV) begin
                apmem_reg <= apm_sat;
            end

            // output register
            if (state_reg == psv_pkg::ST_TK_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            vel_reg <= s_velocity;
            env_reg <= s_envelope_gain;
        end
        unique case (state_reg)
            psv_pkg::ST_PL_MULR: begin
                pl_neg_reg <= prod[P_W-1];
                pl_mag_reg <= pl_abs[21:0];
            end
            psv_pkg::ST_TK_RD1: begin
                cur_reg <= rdata_reg;
            end
            psv_pkg::ST_TK_SUM: begin
                sum_reg <= (SAMPLE_BITS+1)'(cur_reg) + (SAMPLE_BITS+1)'(rdata_reg);
            end
            psv_pkg::ST_TK_AP: begin
                avg_reg <= (SAMPLE_BITS+8)'(prod >>> 8);
            end
            psv_pkg::ST_TK_APSUM: begin
                ap_reg <= ap_sat;
            end
            psv_pkg::ST_TK_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_sample_reg <= smp_sat;
                end
            end
            default: begin
                cur_reg <= cur_reg;
            end
        endcase
    end

endmodule

[src/psv_mul.sv]
// ----------------------------------------------------------------------------
// psv_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module psv_mul #(
    parameter int A_WIDTH = 24,
    parameter int B_WIDTH = 18
) (
    input  logic                               aclk,
    input  logic                               mul_en,
    input  logic signed [A_WIDTH-1:0]          mul_a,
    input  logic signed [B_WIDTH-1:0]          mul_b,
    output logic signed [A_WIDTH+B_WIDTH-1:0]  prod
);

    logic signed [A_WIDTH+B_WIDTH-1:0] prod_reg;

    // Product register, held while the unit is not used
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign prod = prod_reg;

endmodule

[src/psv_checker.sv]
// ----------------------------------------------------------------------------
// psv_checker
// Port-level checks of the plucked string voice, bound to the top level.
// ----------------------------------------------------------------------------
`include "plucked_string_voice_macros.svh"

module psv_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_command,
    input logic                          s_envelope_idle,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_sample
);

    // stalled result word holds
    `PSV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample))

    // a pluck leaves the voice busy after it is accepted, as the burst write begins
    `PSV_ASSERT_NEXT(a_pluck_busy, aclk, aresetn, s_valid && s_ready && s_command == psv_pkg::CMD_PLUCK, !s_ready)

    // a tick with the envelope finished completes at once
    `PSV_ASSERT_NEXT(a_idle_tick, aclk, aresetn, s_valid && s_ready && s_command == psv_pkg::CMD_TICK && s_envelope_idle, s_ready)

    // a new result only appears at the end of a busy tick
    `PSV_ASSERT_SAME(a_result_after_busy, aclk, aresetn, $rose(m_valid), !$past(s_ready))

endmodule

bind plucked_string_voice psv_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_psv_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_command       (s_command),
    .s_envelope_idle (s_envelope_idle),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_sample        (m_sample)
);
